[rtl/dsa_pkg.sv]
// Shared types, constants and helpers for the deadline slot allocator.
// No dependencies; used by dsa_ctrl, dsa_dp and deadline_slot_allocator_unit.
package dsa_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int ROW_W     = 16;      // slot-taken bits per bitmap row
    localparam int POS_W     = 4;       // log2(ROW_W)
    localparam int CFG_W     = 7;
    localparam logic [CFG_W-1:0] CFG_RST = 7'd64;

    localparam int FUNC_W   = 2;
    localparam int DL_W     = 8;
    localparam int PROFIT_W = 16;
    localparam int IDX_W    = 6;
    localparam int SUM_W    = 32;

    localparam logic [FUNC_W-1:0] F_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] F_PLACE = 2'd1;
    localparam logic [FUNC_W-1:0] F_READ  = 2'd2;

    typedef struct packed {
        logic capture;      // latch the accepted item
        logic decode;       // first step: clear, start scan or issue slot read
        logic check;        // examine one bitmap row
        logic read_take;    // slot read data is back
        logic out_load;     // move result into the output register
    } t_dsa_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              top_zero;
        logic              found;
        logic              row_last;
    } t_dsa_sts;

    // index of the highest set bit
    function automatic logic [POS_W-1:0] fls_pos(input logic [ROW_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[rtl/dsa_ctrl.sv]
// Controller state machine for the deadline slot allocator.
// Depends on dsa_pkg; drives commands into dsa_dp and owns both handshakes.
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    input  t_dsa_sts i_sts,
    output t_dsa_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_RDW  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decode = 1'b1;
                case (i_sts.func)
                    F_PLACE: n_state = i_sts.top_zero ? S_DONE : S_CHK;
                    F_READ:  n_state = S_RDW;
                    default: n_state = S_DONE;
                endcase
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                if (i_sts.found || i_sts.row_last) begin
                    n_state = S_DONE;
                end
            end
            S_RDW: begin
                o_cmd.read_take = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DEC))
        else $error("accepted item did not enter decode");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && (i_sts.found || i_sts.row_last)) |=> (r_state == S_DONE))
        else $error("scan did not finish");

    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall || !i_rst_n))
        else $error("result dropped while stalled");

endmodule

[rtl/dsa_dp.sv]
// Datapath for the deadline slot allocator: slot bitmap rows, profit store,
// running total and output register. Depends on dsa_pkg; driven by dsa_ctrl.
module dsa_dp
    import dsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dsa_cmd            i_cmd,
    output t_dsa_sts            o_sts,
    input  logic                i_cfg_wen,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DL_W-1:0]     i_job_deadline,
    input  logic [PROFIT_W-1:0] i_job_profit,
    input  logic [IDX_W-1:0]    i_slot_index,
    output logic                o_placed,
    output logic [IDX_W-1:0]    o_slot_given,
    output logic [SUM_W-1:0]    o_total_profit,
    output logic                o_slot_filled,
    output logic [PROFIT_W-1:0] o_slot_profit
);

    localparam int ROWS = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int RA_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SL_W = $clog2(SLOTS);

    // captured item and config
    logic [FUNC_W-1:0]   r_func;
    logic [DL_W-1:0]     r_deadline;
    logic [PROFIT_W-1:0] r_profit;
    logic [IDX_W-1:0]    r_index;
    logic [CFG_W-1:0]    r_cfg_slots;
    logic [SUM_W-1:0]    r_sum;

    // bitmap rows in memory, one valid flop per row so a clear resets only the flops
    logic [ROW_W-1:0]    taken_mem [ROWS];
    logic [PROFIT_W-1:0] value_mem [SLOTS];
    logic [ROWS-1:0]     r_row_vld;
    logic [ROW_W-1:0]    r_row_q;
    logic [PROFIT_W-1:0] r_val_q;
    logic [RA_W-1:0]     r_row;
    logic [ROW_W-1:0]    r_mask;

    logic                r_res_placed;
    logic [IDX_W-1:0]    r_res_given;
    logic                r_res_filled;
    logic [PROFIT_W-1:0] r_res_profit;

    logic                r_o_placed;
    logic [IDX_W-1:0]    r_o_given;
    logic [SUM_W-1:0]    r_o_total;
    logic                r_o_filled;
    logic [PROFIT_W-1:0] r_o_profit;

    logic [31:0]         lim32, top32, topm1, idx32, slot32;
    logic [RA_W-1:0]     first_row, idx_row, rd_addr;
    logic [POS_W-1:0]    first_pos, hit_pos;
    logic [ROW_W-1:0]    first_mask, row_eff, row_free;
    logic                idx_ok, found, row_last, rd_en, val_rd_en, commit, do_clear;
    logic [SUM_W:0]      sum_add;
    logic [SUM_W-1:0]    sum_next;

    // deadline clamped to the usable slot count
    assign lim32 = (32'(r_cfg_slots) < 32'(SLOTS)) ? 32'(r_cfg_slots) : 32'(SLOTS);
    assign top32 = (32'(r_deadline) < lim32) ? 32'(r_deadline) : lim32;
    assign topm1 = top32 - 32'd1;
    assign first_row  = RA_W'(topm1 >> POS_W);
    assign first_pos  = topm1[POS_W-1:0];
    assign first_mask = {ROW_W{1'b1}} >> (POS_W'(ROW_W - 1) - first_pos);

    assign idx32   = 32'(r_index);
    assign idx_ok  = idx32 < 32'(SLOTS);
    assign idx_row = RA_W'(idx32 >> POS_W);

    assign row_eff  = r_row_vld[r_row] ? r_row_q : '0;
    assign row_free = ~row_eff & r_mask;
    assign found    = |row_free;
    assign hit_pos  = fls_pos(row_free);
    assign slot32   = (32'(r_row) << POS_W) | 32'(hit_pos);
    assign row_last = (r_row == '0);

    assign sum_add  = {1'b0, r_sum} + (SUM_W + 1)'(r_profit);
    assign sum_next = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];

    assign commit   = i_cmd.check && found;
    assign do_clear = i_cmd.decode && (r_func == F_CLEAR);

    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = first_row;
        val_rd_en = 1'b0;
        if (i_cmd.decode && r_func == F_PLACE && top32 != 32'd0) begin
            rd_en = 1'b1;
        end else if (i_cmd.decode && r_func == F_READ && idx_ok) begin
            rd_en     = 1'b1;
            rd_addr   = idx_row;
            val_rd_en = 1'b1;
        end else if (i_cmd.check && !found && !row_last) begin
            rd_en   = 1'b1;
            rd_addr = r_row - RA_W'(1);
        end
    end

    assign o_sts.func     = r_func;
    assign o_sts.top_zero = (top32 == 32'd0);
    assign o_sts.found    = found;
    assign o_sts.row_last = row_last;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_row_q <= taken_mem[rd_addr];
        end
        if (commit) begin
            taken_mem[r_row] <= row_eff | (ROW_W'(1) << hit_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (val_rd_en) begin
            r_val_q <= value_mem[SL_W'(r_index)];
        end
        if (commit) begin
            value_mem[SL_W'(slot32)] <= r_profit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_slots <= CFG_RST;
            r_sum       <= '0;
            r_row_vld   <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_cfg_slots <= i_cfg_wdata;
            end
            if (do_clear) begin
                r_sum     <= '0;
                r_row_vld <= '0;
            end else if (commit) begin
                r_sum            <= sum_next;
                r_row_vld[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func     <= i_func;
            r_deadline <= i_job_deadline;
            r_profit   <= i_job_profit;
            r_index    <= i_slot_index;
        end
        if (rd_en) begin
            r_row <= rd_addr;
        end
        if (i_cmd.decode) begin
            r_mask       <= first_mask;
            r_res_placed <= 1'b0;
            r_res_given  <= '0;
            r_res_filled <= 1'b0;
            r_res_profit <= '0;
        end else if (i_cmd.check) begin
            r_mask <= '1;
            if (found) begin
                r_res_placed <= 1'b1;
                r_res_given  <= IDX_W'(slot32);
            end
        end else if (i_cmd.read_take) begin
            if (idx_ok && row_eff[r_index[POS_W-1:0]]) begin
                r_res_filled <= 1'b1;
                r_res_profit <= r_val_q;
            end
        end
        if (i_cmd.out_load) begin
            r_o_placed <= r_res_placed;
            r_o_given  <= r_res_given;
            r_o_total  <= r_sum;
            r_o_filled <= r_res_filled;
            r_o_profit <= r_res_profit;
        end
    end

    assign o_placed       = r_o_placed;
    assign o_slot_given   = r_o_given;
    assign o_total_profit = r_o_total;
    assign o_slot_filled  = r_o_filled;
    assign o_slot_profit  = r_o_profit;

    a_slot_below_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (slot32 < top32))
        else $error("slot picked at or above clamped deadline");

    a_sum_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_sum >= $past(r_sum)))
        else $error("total decreased on placement");

    a_clear_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_clear |=> (r_sum == '0 && r_row_vld == '0))
        else $error("clear left state behind");

endmodule

[rtl/deadline_slot_allocator_unit.sv]
// Per item: clear or no-op decode, done; read decode, read-wait, done; place decode,
// rows scanned (none for a zero clamped deadline, else 1 .. ceil(SLOTS/16)), one
// 16-slot bitmap row per cycle, then done, held while i_stall holds the last result.
// One item at a time: the next is taken in the cycle after a result enters the
// output register. Synchronous active-low reset empties all slots, zeroes the total
// and sets the slot count to 64. Top level; depends on dsa_pkg, dsa_ctrl and dsa_dp.
module deadline_slot_allocator_unit
    import dsa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wen,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [DL_W-1:0]     i_job_deadline,
    input  logic [PROFIT_W-1:0] i_job_profit,
    input  logic [IDX_W-1:0]    i_slot_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_placed,
    output logic [IDX_W-1:0]    o_slot_given,
    output logic [SUM_W-1:0]    o_total_profit,
    output logic                o_slot_filled,
    output logic [PROFIT_W-1:0] o_slot_profit
);

    t_dsa_cmd cmd;
    t_dsa_sts sts;

    dsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dsa_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_job_deadline (i_job_deadline),
        .i_job_profit   (i_job_profit),
        .i_slot_index   (i_slot_index),
        .o_placed       (o_placed),
        .o_slot_given   (o_slot_given),
        .o_total_profit (o_total_profit),
        .o_slot_filled  (o_slot_filled),
        .o_slot_profit  (o_slot_profit)
    );

endmodule
